### rtl/core/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package uvst_pkg;

	localparam int CFG_SECTOR = 0;
	localparam int CFG_STACK = 1;
	localparam int TABLE_LEN = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef logic signed [33:0] cv_t;

	function automatic logic [31:0] turn_atan(input int k);
		logic [31:0] r;
		case (k)
			0: r = 32'd536870912;
			1: r = 32'd316933405;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335086;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41721;
			15: r = 32'd20860;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2607;
			19: r = 32'd1303;
			20: r = 32'd651;
			21: r = 32'd325;
			22: r = 32'd162;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// side data carried alongside the cordic
	typedef struct packed {
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [15:0] k1;
		logic [15:0] k2;
		logic upper;
		logic lower;
		logic in_grid;
	} side_t;

endpackage

### rtl/core/uvst_div.sv
// ----------------------------------------------------------------------------
// uvst_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module uvst_div #(
	parameter int NW = 41,
	parameter int DW = 9
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic [NW-1:0] quo
);
	logic [NW-1:0] n_q [0:NW];
	logic [NW-1:0] q_q [0:NW];
	logic [DW-1:0] d_q [0:NW];
	logic [DW:0] r_q [0:NW];

	always_comb begin
		n_q[0] = num;
		d_q[0] = den;
		q_q[0] = '0;
		r_q[0] = '0;
	end

	for (genvar g = 0; g < NW; g++) begin : g_st
		logic [DW+1:0] tr;
		logic [DW+1:0] df;
		assign tr = {r_q[g], n_q[g][NW-1-g]};
		assign df = tr - {2'b00, d_q[g]};
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[g+1] <= n_q[g];
				d_q[g+1] <= d_q[g];
				if (!df[DW+1]) begin
					r_q[g+1] <= df[DW:0];
					q_q[g+1] <= q_q[g] | (NW'(1) << (NW-1-g));
				end else begin
					r_q[g+1] <= tr[DW:0];
					q_q[g+1] <= q_q[g];
				end
			end
		end
	end

	assign quo = q_q[NW];
endmodule

### rtl/core/uvst_cordic.sv
// ----------------------------------------------------------------------------
// uvst_cordic
// pipelined rotation cordic, cosine and sine of a turn fraction
// ----------------------------------------------------------------------------
module uvst_cordic #(
	parameter int STAGES = 16
) (
	input logic clk,
	input logic en,
	input logic [31:0] ang,
	output uvst_pkg::cv_t cos_o,
	output uvst_pkg::cv_t sin_o
);
	import uvst_pkg::*;

	cv_t x_q [0:STAGES];
	cv_t y_q [0:STAGES];
	logic signed [33:0] z_q [0:STAGES];
	logic [1:0] qd_q [0:STAGES];

	always_comb begin
		x_q[0] = CORDIC_GAIN;
		y_q[0] = '0;
		z_q[0] = {4'b0, ang[29:0]};
		qd_q[0] = ang[31:30];
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				qd_q[g+1] <= qd_q[g];
				if (!z_q[g][33]) begin
					x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
					y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
					z_q[g+1] <= z_q[g] - $signed({2'b0, turn_atan(g)});
				end else begin
					x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
					y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
					z_q[g+1] <= z_q[g] + $signed({2'b0, turn_atan(g)});
				end
			end
		end
	end

	always_comb begin
		case (qd_q[STAGES])
			2'd0: begin cos_o = x_q[STAGES]; sin_o = y_q[STAGES]; end
			2'd1: begin cos_o = -y_q[STAGES]; sin_o = x_q[STAGES]; end
			2'd2: begin cos_o = -x_q[STAGES]; sin_o = -y_q[STAGES]; end
			default: begin cos_o = y_q[STAGES]; sin_o = -x_q[STAGES]; end
		endcase
	end
endmodule

### rtl/core/uv_sphere_tessellator_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator_core
// stages: index register, dividend set-up, angle dividers, cordic pipeline,
// products and rounding; throughput one transaction per cycle unless stalled
// the whole pipeline advances unless the output stage is held by stall
// reset clears valid bits and loads sector_count 36, stack_count 18
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_core #(
	parameter int MAX_DIVISIONS = 255,
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] stack_index,
	input logic [7:0] sector_index,
	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic [16:0] tex_u,
	output logic [16:0] tex_v,
	output logic [15:0] top_vertex_index,
	output logic [15:0] bottom_vertex_index,
	output logic upper_triangle_valid,
	output logic lower_triangle_valid,
	output logic point_valid,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data
);
	import uvst_pkg::*;

	localparam int DL = 41;
	localparam logic [7:0] MAXD = 8'(MAX_DIVISIONS);

	logic [7:0] sec_cnt_q, stk_cnt_q;
	logic en;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_cnt_q <= 8'd36;
			stk_cnt_q <= 8'd18;
		end else if (cfg_valid) begin
			if (cfg_index == 1'(CFG_SECTOR)) sec_cnt_q <= cfg_data;
			else stk_cnt_q <= cfg_data;
		end
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: clamp counts, register indices
	logic v_s1;
	logic [7:0] i_s1, j_s1, s_s1, t_s1;
	logic [7:0] s_eff, t_eff;
	always_comb begin
		s_eff = sec_cnt_q < 8'd3 ? 8'd3 : sec_cnt_q;
		if (s_eff > MAXD) s_eff = MAXD;
		t_eff = stk_cnt_q < 8'd2 ? 8'd2 : stk_cnt_q;
		if (t_eff > MAXD) t_eff = MAXD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			i_s1 <= stack_index;
			j_s1 <= sector_index;
			s_s1 <= s_eff;
			t_s1 <= t_eff;
		end
	end

	// stage 2: dividend set-up, indices and flags
	logic v_s2;
	logic [40:0] sa_num_s2, sk_num_s2, tu_num_s2, tv_num_s2;
	logic [8:0] s_den_s2, t_den_s2;
	side_t sd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		logic [15:0] k1;
		logic quad;
		if (en) begin
			k1 = 16'(i_s1) * (16'(s_s1) + 16'd1) + 16'(j_s1);
			quad = (i_s1 < t_s1) && (j_s1 < s_s1);
			sa_num_s2 <= {1'b0, j_s1, 32'd0} + 41'(s_s1 >> 1);
			sk_num_s2 <= {1'b0, i_s1, 32'd0} + 41'(t_s1);
			tu_num_s2 <= 41'({j_s1, 16'd0}) + 41'(s_s1 >> 1);
			tv_num_s2 <= 41'({i_s1, 16'd0}) + 41'(t_s1 >> 1);
			s_den_s2 <= {1'b0, s_s1};
			t_den_s2 <= {t_s1, 1'b0};
			sd_s2.k1 <= k1;
			sd_s2.k2 <= k1 + 16'(s_s1) + 16'd1;
			sd_s2.upper <= quad && (i_s1 != 8'd0);
			sd_s2.lower <= quad && (i_s1 != t_s1 - 8'd1);
			sd_s2.in_grid <= (i_s1 <= t_s1) && (j_s1 <= s_s1);
			sd_s2.tex_u <= '0;
			sd_s2.tex_v <= '0;
		end
	end

	logic [40:0] sa_q, sk_q, tu_q, tv_q;
	uvst_div u_div_sa (.clk, .en, .num(sa_num_s2), .den(s_den_s2), .quo(sa_q));
	uvst_div u_div_sk (.clk, .en, .num(sk_num_s2), .den(t_den_s2), .quo(sk_q));
	uvst_div u_div_tu (.clk, .en, .num(tu_num_s2), .den(s_den_s2), .quo(tu_q));
	uvst_div u_div_tv (.clk, .en, .num(tv_num_s2),
		.den({1'b0, t_den_s2[8:1]}), .quo(tv_q));

	// side data delay across the dividers
	side_t sd_d [0:DL];
	logic v_d [0:DL];
	assign sd_d[0] = sd_s2;
	assign v_d[0] = v_s2;
	for (genvar g = 0; g < DL; g++) begin : g_dd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[g+1] <= 1'b0;
			else if (en) v_d[g+1] <= v_d[g];
		end
		always_ff @(posedge clk) if (en) sd_d[g+1] <= sd_d[g];
	end

	side_t sd_c;
	always_comb begin
		sd_c = sd_d[DL];
		sd_c.tex_u = tu_q > 41'd65536 ? 17'd65536 : tu_q[16:0];
		sd_c.tex_v = tv_q > 41'd65536 ? 17'd65536 : tv_q[16:0];
	end

	logic [31:0] stk_ang;
	assign stk_ang = 32'h4000_0000 - sk_q[31:0];

	cv_t ca, sa, cb, sb;
	uvst_cordic #(.STAGES(CORDIC_STAGES)) u_cor_a (.clk, .en, .ang(stk_ang),
		.cos_o(ca), .sin_o(sa));
	uvst_cordic #(.STAGES(CORDIC_STAGES)) u_cor_b (.clk, .en, .ang(sa_q[31:0]),
		.cos_o(cb), .sin_o(sb));

	side_t sd_e [0:CORDIC_STAGES];
	logic v_e [0:CORDIC_STAGES];
	assign sd_e[0] = sd_c;
	assign v_e[0] = v_d[DL];
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_de
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_e[g+1] <= 1'b0;
			else if (en) v_e[g+1] <= v_e[g];
		end
		always_ff @(posedge clk) if (en) sd_e[g+1] <= sd_e[g];
	end

	// stage m: products
	logic v_sm;
	logic signed [67:0] px_sm, py_sm;
	logic signed [33:0] sz_sm;
	side_t sd_sm;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sm <= 1'b0;
		else if (en) v_sm <= v_e[CORDIC_STAGES];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			px_sm <= ca * cb;
			py_sm <= ca * sb;
			sz_sm <= sa;
			sd_sm <= sd_e[CORDIC_STAGES];
		end
	end

	// stage r: rounding and saturation
	function automatic logic [15:0] sat(input logic signed [67:0] v);
		if (v > 68'sd32767) return 16'h7fff;
		if (v < -68'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	logic signed [67:0] rx, ry, rz;
	assign rx = (px_sm + (68'sd1 <<< 44)) >>> 45;
	assign ry = (py_sm + (68'sd1 <<< 44)) >>> 45;
	assign rz = (68'(sz_sm) + 68'sd16384) >>> 15;

	logic v_so;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_so <= 1'b0;
		else if (en) v_so <= v_sm;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pos_x <= sat(rx);
			pos_y <= sat(ry);
			pos_z <= sat(rz);
			tex_u <= sd_sm.tex_u;
			tex_v <= sd_sm.tex_v;
			top_vertex_index <= sd_sm.k1;
			bottom_vertex_index <= sd_sm.k2;
			upper_triangle_valid <= sd_sm.upper;
			lower_triangle_valid <= sd_sm.lower;
			point_valid <= sd_sm.in_grid;
		end
	end
	assign out_valid = v_so;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(top_vertex_index))
		else $error("result lost under stall");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> !upper_triangle_valid && !lower_triangle_valid)
		else $error("triangle flag outside grid");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 |=> v_s2)
		else $error("valid dropped");
endmodule

### verif/uv_sphere_tessellator_checker.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator_checker
// watches the point, result and register channels of the tessellator core,
// computes the expected vertex, texture, index and triangle flags of each
// accepted point and compares them in order with the results that come out
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] stack_index,
	input logic [7:0] sector_index,
	input logic out_valid,
	input logic out_stall,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic [15:0] pos_z,
	input logic [16:0] tex_u,
	input logic [16:0] tex_v,
	input logic [15:0] top_vertex_index,
	input logic [15:0] bottom_vertex_index,
	input logic upper_triangle_valid,
	input logic lower_triangle_valid,
	input logic point_valid,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data,
	output int fail_count,
	output int points_pending
);
	import uvst_pkg::*;

	localparam int STAGES = 16;
	localparam int MAX_DIV = 255;

	typedef struct {
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pz;
		logic [16:0] u;
		logic [16:0] v;
		logic [15:0] k1;
		logic [15:0] k2;
		logic upper;
		logic lower;
		logic in_grid;
	} vertex_t;

	longint atan_turn [24] = '{
		536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335086, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81
	};

	logic [7:0] sectors_reg;
	logic [7:0] stacks_reg;
	vertex_t vertex_q [$];

	function automatic longint clamp_count(logic [7:0] v, longint low);
		longint r;
		r = longint'(v);
		if (r < low)
			r = low;
		if (r > MAX_DIV)
			r = MAX_DIV;
		return r;
	endfunction

	function automatic longint sat_q15(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint frac_q16(longint num, longint den);
		longint r;
		r = ((num << 16) + den / 2) / den;
		return (r > 65536) ? 65536 : r;
	endfunction

	function automatic void turn_sincos(input logic [31:0] ang, output longint c,
			output longint s);
		longint x, y, z, nx, ny;
		x = 652032874;
		y = 0;
		z = longint'(ang[29:0]);
		for (int k = 0; k < STAGES; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k);
				ny = y + (x >>> k);
				z = z - atan_turn[k];
			end else begin
				nx = x + (y >>> k);
				ny = y - (x >>> k);
				z = z + atan_turn[k];
			end
			x = nx;
			y = ny;
		end
		case (ang[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic vertex_t grid_vertex(logic [7:0] i8, logic [7:0] j8);
		vertex_t r;
		longint sc, tc, i, j, ca, sa, cb, sb;
		logic [63:0] sec_w, off_w;
		logic [31:0] stk_ang;
		bit quad;
		sc = clamp_count(sectors_reg, 3);
		tc = clamp_count(stacks_reg, 2);
		i = longint'(i8);
		j = longint'(j8);
		sec_w = ((j << 32) + sc / 2) / sc;
		off_w = ((i << 32) + tc) / (2 * tc);
		stk_ang = 32'h40000000 - off_w[31:0];
		turn_sincos(stk_ang, ca, sa);
		turn_sincos(sec_w[31:0], cb, sb);
		r.px = 16'(sat_q15((ca * cb + (longint'(1) << 44)) >>> 45));
		r.py = 16'(sat_q15((ca * sb + (longint'(1) << 44)) >>> 45));
		r.pz = 16'(sat_q15((sa + (longint'(1) << 14)) >>> 15));
		r.u = 17'(frac_q16(j, sc));
		r.v = 17'(frac_q16(i, tc));
		r.k1 = 16'(i * (sc + 1) + j);
		r.k2 = 16'(longint'(r.k1) + sc + 1);
		quad = (i < tc) && (j < sc);
		r.upper = quad && (i != 0);
		r.lower = quad && (i != tc - 1);
		r.in_grid = (i <= tc) && (j <= sc);
		return r;
	endfunction

	function automatic int field_check(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	assign points_pending = vertex_q.size();

	always @(posedge clk or negedge arst_n) begin
		vertex_t w;
		int bad;
		if (!arst_n) begin
			sectors_reg <= 8'd36;
			stacks_reg <= 8'd18;
			fail_count <= 0;
			vertex_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SECTOR)
					sectors_reg <= cfg_data;
				else if (cfg_index == CFG_STACK)
					stacks_reg <= cfg_data;
			end
			if (in_valid && !in_stall)
				vertex_q = {vertex_q, grid_vertex(stack_index, sector_index)};
			if (out_valid && !out_stall) begin
				if (vertex_q.size() == 0) begin
					$error("result transaction with no point outstanding");
					fail_count <= fail_count + 1;
				end else begin
					w = vertex_q.pop_front();
					bad = 0;
					bad += field_check("pos_x", $signed(w.px), $signed(pos_x));
					bad += field_check("pos_y", $signed(w.py), $signed(pos_y));
					bad += field_check("pos_z", $signed(w.pz), $signed(pos_z));
					bad += field_check("tex_u", w.u, tex_u);
					bad += field_check("tex_v", w.v, tex_v);
					bad += field_check("top_vertex_index", w.k1, top_vertex_index);
					bad += field_check("bottom_vertex_index", w.k2, bottom_vertex_index);
					bad += field_check("upper_triangle_valid", w.upper, upper_triangle_valid);
					bad += field_check("lower_triangle_valid", w.lower, lower_triangle_valid);
					bad += field_check("point_valid", w.in_grid, point_valid);
					if (bad != 0)
						fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule

### verif/uv_sphere_tessellator_core_test.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator_core_test
// drives grid points through the tessellator core under several grid sizes,
// with random idling on both sides and one long output hold-off, and leaves
// the checking to the checker beside the core
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_core_test;
	import uvst_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] stack_index = '0;
	logic [7:0] sector_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic [16:0] tex_u, tex_v;
	logic [15:0] top_vertex_index, bottom_vertex_index;
	logic upper_triangle_valid, lower_triangle_valid, point_valid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	int fail_count;
	int points_pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_output = 0;
	bit point_taken, cfg_taken;
	int quiet_cycles = 0;
	int cur_sectors = 36;
	int cur_stacks = 18;

	uv_sphere_tessellator_core DUT (.*);

	uv_sphere_tessellator_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		point_taken <= in_valid && !in_stall;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= hold_output || ($urandom_range(99) < recv_idle_pct);

	task automatic send_point(int i, int j);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			stack_index <= 8'($urandom);
			sector_index <= 8'($urandom);
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		stack_index <= 8'(i);
		sector_index <= 8'(j);
		do @(negedge clk); while (!point_taken);
	endtask

	task automatic drain_points();
		in_valid <= 1'b0;
		@(negedge clk);
		while (points_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(int idx, logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx[0:0];
		cfg_data <= value;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(logic [7:0] sectors, logic [7:0] stacks);
		drain_points();
		write_reg(CFG_SECTOR, sectors);
		write_reg(CFG_STACK, stacks);
		cur_sectors = (sectors < 3) ? 3 : sectors;
		cur_stacks = (stacks < 2) ? 2 : stacks;
	endtask

	task automatic random_points(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 85)
				send_point($urandom_range(cur_stacks), $urandom_range(cur_sectors));
			else
				send_point($urandom, $urandom);
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_point(0, 0);
		send_point(18, 36);
		send_point(17, 0);
		send_point(17, 35);
		send_point(1, 5);
		send_point(9, 9);
		send_point(9, 18);
		send_point(18, 0);
		send_point(0, 36);
		send_point(19, 0);
		send_point(0, 37);
		send_point(255, 255);
		send_point(255, 0);
		send_point(0, 255);
		send_point(170, 85);
		send_point(85, 170);

		send_idle_pct = 30;
		recv_idle_pct = 49;
		set_grid(8'd3, 8'd2);
		random_points(240);
		set_grid(8'd255, 8'd255);
		random_points(240);

		send_idle_pct = 49;
		recv_idle_pct = 30;
		set_grid(8'd0, 8'd0);
		random_points(240);
		set_grid(8'd1, 8'd1);
		random_points(240);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_grid(8'($urandom_range(3, 255)), 8'($urandom_range(2, 255)));
		fork
			begin
				hold_output = 1;
				repeat (300) @(negedge clk);
				hold_output = 0;
			end
		join_none
		random_points(240);
		set_grid(8'd200, 8'd100);
		random_points(240);

		drain_points();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### uv_sphere_tessellator_core.f
rtl/core/uvst_pkg.sv
rtl/core/uvst_div.sv
rtl/core/uvst_cordic.sv
rtl/core/uv_sphere_tessellator_core.sv
verif/uv_sphere_tessellator_checker.sv
verif/uv_sphere_tessellator_core_test.sv
